// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the trace parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is applied.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("trace parser assertion failed");

// Next-cycle implication, disabled while the active-low reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("trace parser assertion failed");

`endif

// File: hw/rtl/atrp_pkg.sv
// Shared types, codes and constants of the allocation-trace record parser.
// No dependencies; used by every module of the block but atrp_fifo, by scoped names.
package atrp_pkg;

  // Default parameter values and fixed field widths.
  localparam int unsigned WORD_CHARS_DEF   = 8;
  localparam int unsigned POINTER_BITS_DEF = 32;
  localparam int unsigned CHAR_Q_DEPTH     = 4;
  localparam int unsigned REC_Q_DEPTH      = 2;
  localparam int unsigned SIZE_W           = 63;
  localparam int unsigned PTR_W            = 32;
  localparam int unsigned WORD_BUF_W       = 56;

  // Characters with a meaning of their own.
  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_TAB   = 8'h09;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_LC_A  = 8'h61;
  localparam logic [7:0] ASCII_LC_F  = 8'h66;
  localparam logic [7:0] ASCII_UC_A  = 8'h41;
  localparam logic [7:0] ASCII_UC_F  = 8'h46;
  localparam logic [7:0] ASCII_LC_X  = 8'h78;
  localparam logic [7:0] ASCII_UC_X  = 8'h58;

  // Keywords packed one byte per character, last character lowest.
  localparam logic [WORD_BUF_W-1:0] KW_MALLOC  = 56'h00_4D414C4C4F43;
  localparam logic [WORD_BUF_W-1:0] KW_CALLOC  = 56'h00_43414C4C4F43;
  localparam logic [WORD_BUF_W-1:0] KW_REALLOC = 56'h52454_14C4C4F43;
  localparam logic [WORD_BUF_W-1:0] KW_FREE    = 56'h00_0000_46524545;
  localparam logic [3:0] KW_MALLOC_LEN  = 4'd6;
  localparam logic [3:0] KW_CALLOC_LEN  = 4'd6;
  localparam logic [3:0] KW_REALLOC_LEN = 4'd7;
  localparam logic [3:0] KW_FREE_LEN    = 4'd4;

  // Event kind codes as they appear on the result port.
  localparam logic [1:0] EV_MALLOC  = 2'd0;
  localparam logic [1:0] EV_CALLOC  = 2'd1;
  localparam logic [1:0] EV_REALLOC = 2'd2;
  localparam logic [1:0] EV_FREE    = 2'd3;

  typedef enum logic [1:0] {
    PH_LOC,
    PH_TYPE,
    PH_INPUT,
    PH_OUTPUT
  } phase_e;

  typedef enum logic [2:0] {
    K_MALLOC,
    K_CALLOC,
    K_REALLOC,
    K_FREE,
    K_NONE
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_KEYWORD,
    ERR_STRAY_SPACE,
    ERR_STRAY_TAB,
    ERR_OVERFLOW,
    ERR_NO_KIND,
    ERR_MISPLACED
  } err_e;

  typedef enum logic [1:0] {
    CC_NEWLINE,
    CC_TAB,
    CC_SPACE,
    CC_OTHER
  } chclass_e;

  // One classified character, as the front hands it to the back.
  typedef struct packed {
    chclass_e   cls;
    logic       is_dec;
    logic       is_hex;
    logic       is_x;
    logic [3:0] digit;
    logic [7:0] raw;
  } chr_t;

  // One result record.
  typedef struct packed {
    logic [1:0]        event_kind;
    logic [SIZE_W-1:0] alloc_size;
    logic [SIZE_W-1:0] member_count;
    logic [PTR_W-1:0]  old_pointer;
    logic [PTR_W-1:0]  new_pointer;
    err_e              error_code;
  } rec_t;

endpackage

// File: hw/rtl/atrp_fifo.sv
// Small first-in first-out queue of register entries, used between stages.
// Depends on nothing; the entry type is a parameter.
module atrp_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [AddrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en, rd_en;

  // Handshake qualification.
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      wr_d = (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (rd_en) begin
      rd_d = (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/atrp_front.sv
// Front of the trace parser: accepts characters, classifies them and queues them.
// Depends on atrp_pkg and atrp_fifo.
module atrp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     ch_i,
  output logic           full_o,
  input  logic           pop_i,
  output atrp_pkg::chr_t chr_o,
  output logic           empty_o
);

  atrp_pkg::chr_t chr_in;
  logic           is_lc_hex, is_uc_hex;

  // Character class and digit values.
  always_comb begin
    chr_in.raw    = ch_i;
    chr_in.is_dec = (ch_i >= atrp_pkg::ASCII_0) && (ch_i <= atrp_pkg::ASCII_9);
    is_lc_hex     = (ch_i >= atrp_pkg::ASCII_LC_A) && (ch_i <= atrp_pkg::ASCII_LC_F);
    is_uc_hex     = (ch_i >= atrp_pkg::ASCII_UC_A) && (ch_i <= atrp_pkg::ASCII_UC_F);
    chr_in.is_hex = chr_in.is_dec || is_lc_hex || is_uc_hex;
    chr_in.is_x   = (ch_i == atrp_pkg::ASCII_LC_X) || (ch_i == atrp_pkg::ASCII_UC_X);
    // Letters a-f and A-F have low nibbles 1 to 6.
    chr_in.digit  = chr_in.is_dec ? ch_i[3:0] : 4'(ch_i[3:0] + 4'd9);
    if (ch_i == atrp_pkg::ASCII_LF) begin
      chr_in.cls = atrp_pkg::CC_NEWLINE;
    end else if (ch_i == atrp_pkg::ASCII_TAB) begin
      chr_in.cls = atrp_pkg::CC_TAB;
    end else if (ch_i == atrp_pkg::ASCII_SPACE) begin
      chr_in.cls = atrp_pkg::CC_SPACE;
    end else begin
      chr_in.cls = atrp_pkg::CC_OTHER;
    end
  end

  // Queue toward the back, so each side stalls on its own.
  atrp_fifo #(
    .item_t (atrp_pkg::chr_t),
    .Depth  (atrp_pkg::CHAR_Q_DEPTH)
  ) u_char_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (chr_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (chr_o),
    .empty_o (empty_o)
  );

endmodule

// File: hw/rtl/atrp_back.sv
// Back of the trace parser: line state machine, number accumulators and records.
// Depends on atrp_pkg.
module atrp_back #(
  parameter int unsigned WORD_CHARS   = atrp_pkg::WORD_CHARS_DEF,
  parameter int unsigned POINTER_BITS = atrp_pkg::POINTER_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  atrp_pkg::chr_t chr_i,
  input  logic           chr_valid_i,
  output logic           chr_pop_o,
  input  logic           rec_full_i,
  output logic           rec_push_o,
  output atrp_pkg::rec_t rec_o
);

  localparam int unsigned HexW = (POINTER_BITS < atrp_pkg::PTR_W) ?
                                 POINTER_BITS : atrp_pkg::PTR_W;
  localparam logic [4:0]  WordCap = 5'(WORD_CHARS);
  localparam int unsigned SW = atrp_pkg::SIZE_W;

  atrp_pkg::phase_e phase_q, phase_d;
  atrp_pkg::kind_e  kind_q, kind_d;
  logic [SW-1:0]    dec_q, dec_d;
  logic [HexW-1:0]  hex_q, hex_d;
  logic             dstop_q, dstop_d, hstop_q, hstop_d, dovf_q, dovf_d;
  logic [atrp_pkg::WORD_BUF_W-1:0] word_q, word_d;
  logic [3:0]       wlen_q, wlen_d, wlen_inc;
  logic [SW-1:0]    held_size_q, held_size_d, held_mem_q, held_mem_d;
  logic [HexW-1:0]  held_old_q, held_old_d;
  logic             discard_q, discard_d;

  logic             fire;
  atrp_pkg::err_e   err;
  logic             emit, restart, clr, to_type, to_input, to_output;
  logic             set_kind, take_size, take_mem, take_old, word_push, num_push;
  logic             kw_hit;
  atrp_pkg::kind_e  kw_kind;
  logic [SW+3:0]    dec_next;
  logic             dec_ovf;

  assign fire      = chr_valid_i && !rec_full_i;
  assign chr_pop_o = fire;

  // Keyword lookup on the collected word.
  always_comb begin
    kw_hit  = 1'b1;
    kw_kind = atrp_pkg::K_NONE;
    priority if (wlen_q == atrp_pkg::KW_MALLOC_LEN && word_q == atrp_pkg::KW_MALLOC) begin
      kw_kind = atrp_pkg::K_MALLOC;
    end else if (wlen_q == atrp_pkg::KW_CALLOC_LEN && word_q == atrp_pkg::KW_CALLOC) begin
      kw_kind = atrp_pkg::K_CALLOC;
    end else if (wlen_q == atrp_pkg::KW_REALLOC_LEN &&
                 word_q == atrp_pkg::KW_REALLOC) begin
      kw_kind = atrp_pkg::K_REALLOC;
    end else if (wlen_q == atrp_pkg::KW_FREE_LEN && word_q == atrp_pkg::KW_FREE) begin
      kw_kind = atrp_pkg::K_FREE;
    end else begin
      kw_hit = 1'b0;
    end
  end

  // Decimal step: ten times the value plus the digit, overflow past 63 bits.
  assign dec_next = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0} + {63'd0, chr_i.digit};
  assign dec_ovf  = |dec_next[SW+3:SW];
  assign wlen_inc = (wlen_q == 4'hF) ? wlen_q : wlen_q + 4'd1;

  // Decode one character into actions; an error blocks all other updates but a newline's restart.
  always_comb begin
    err       = atrp_pkg::ERR_NONE;
    emit      = 1'b0;
    restart   = 1'b0;
    clr       = 1'b0;
    to_type   = 1'b0;
    to_input  = 1'b0;
    to_output = 1'b0;
    set_kind  = 1'b0;
    take_size = 1'b0;
    take_mem  = 1'b0;
    take_old  = 1'b0;
    word_push = 1'b0;
    num_push  = 1'b0;
    if (fire) begin
      if (discard_q) begin
        restart = (chr_i.cls == atrp_pkg::CC_NEWLINE);
      end else begin
        unique case (chr_i.cls)
          atrp_pkg::CC_NEWLINE: begin
            restart = 1'b1;
            if (kind_q == atrp_pkg::K_NONE) begin
              err = atrp_pkg::ERR_NO_KIND;
            end else if ((kind_q == atrp_pkg::K_FREE) ? (phase_q != atrp_pkg::PH_INPUT)
                                                      : (phase_q != atrp_pkg::PH_OUTPUT)) begin
              err = atrp_pkg::ERR_MISPLACED;
            end else begin
              emit = 1'b1;
            end
          end
          atrp_pkg::CC_TAB: begin
            unique case (phase_q)
              atrp_pkg::PH_LOC: begin
                clr     = 1'b1;
                to_type = 1'b1;
              end
              atrp_pkg::PH_INPUT: begin
                if (kind_q == atrp_pkg::K_FREE) begin
                  err = atrp_pkg::ERR_MISPLACED;
                end else if (dovf_q) begin
                  err = atrp_pkg::ERR_OVERFLOW;
                end else begin
                  take_size = 1'b1;
                  clr       = 1'b1;
                  to_output = 1'b1;
                end
              end
              atrp_pkg::PH_TYPE, atrp_pkg::PH_OUTPUT: begin
                err = atrp_pkg::ERR_STRAY_TAB;
              end
            endcase
          end
          atrp_pkg::CC_SPACE: begin
            unique case (phase_q)
              atrp_pkg::PH_TYPE: begin
                if (kw_hit) begin
                  set_kind = 1'b1;
                  clr      = 1'b1;
                  to_input = 1'b1;
                end else begin
                  err = atrp_pkg::ERR_BAD_KEYWORD;
                end
              end
              atrp_pkg::PH_INPUT: begin
                if (kind_q == atrp_pkg::K_CALLOC) begin
                  if (dovf_q) begin
                    err = atrp_pkg::ERR_OVERFLOW;
                  end else begin
                    take_mem = 1'b1;
                    clr      = 1'b1;
                  end
                end else if (kind_q == atrp_pkg::K_REALLOC) begin
                  take_old = 1'b1;
                  clr      = 1'b1;
                end else begin
                  err = atrp_pkg::ERR_MISPLACED;
                end
              end
              atrp_pkg::PH_LOC, atrp_pkg::PH_OUTPUT: begin
                err = atrp_pkg::ERR_STRAY_SPACE;
              end
            endcase
          end
          atrp_pkg::CC_OTHER: begin
            unique case (phase_q)
              atrp_pkg::PH_TYPE: begin
                if ({1'b0, wlen_q} >= WordCap) begin
                  err = atrp_pkg::ERR_BAD_KEYWORD;
                end else begin
                  word_push = 1'b1;
                end
              end
              atrp_pkg::PH_INPUT, atrp_pkg::PH_OUTPUT: begin
                num_push = 1'b1;
              end
              atrp_pkg::PH_LOC: begin
                num_push = 1'b0;
              end
            endcase
          end
        endcase
      end
    end
  end

  // Line phase state machine: next state.
  always_comb begin
    phase_d = phase_q;
    if (restart) begin
      phase_d = atrp_pkg::PH_LOC;
    end else if (to_type) begin
      phase_d = atrp_pkg::PH_TYPE;
    end else if (to_input) begin
      phase_d = atrp_pkg::PH_INPUT;
    end else if (to_output) begin
      phase_d = atrp_pkg::PH_OUTPUT;
    end
  end

  // Line phase state machine: record output for the result queue.
  always_comb begin
    rec_push_o = fire && (emit || (err != atrp_pkg::ERR_NONE));
    rec_o      = '0;
    rec_o.error_code = err;
    if (emit) begin
      rec_o.event_kind   = kind_q[1:0];
      rec_o.alloc_size   = (kind_q == atrp_pkg::K_FREE) ? '0 : held_size_q;
      rec_o.member_count = (kind_q == atrp_pkg::K_CALLOC) ? held_mem_q : '0;
      rec_o.old_pointer  = (kind_q == atrp_pkg::K_REALLOC) ?
                           atrp_pkg::PTR_W'(held_old_q) : '0;
      rec_o.new_pointer  = atrp_pkg::PTR_W'(hex_q);
    end
  end

  // Field accumulators, keyword buffer and held fields.
  always_comb begin
    kind_d      = kind_q;
    dec_d       = dec_q;
    hex_d       = hex_q;
    dstop_d     = dstop_q;
    hstop_d     = hstop_q;
    dovf_d      = dovf_q;
    word_d      = word_q;
    wlen_d      = wlen_q;
    held_size_d = held_size_q;
    held_mem_d  = held_mem_q;
    held_old_d  = held_old_q;
    discard_d   = discard_q;

    if (err != atrp_pkg::ERR_NONE) begin
      discard_d = 1'b1;
    end
    if (set_kind) begin
      kind_d = kw_kind;
    end
    if (take_size) begin
      held_size_d = dec_q;
    end
    if (take_mem) begin
      held_mem_d = dec_q;
    end
    if (take_old) begin
      held_old_d = hex_q;
    end

    // Keyword characters shift in at the low end.
    if (word_push) begin
      word_d = {word_q[atrp_pkg::WORD_BUF_W-9:0], chr_i.raw};
      wlen_d = wlen_inc;
    end

    // Number characters feed the decimal and hex readings side by side.
    if (num_push) begin
      wlen_d = wlen_inc;
      if (!dstop_q) begin
        if (chr_i.is_dec) begin
          if (!dovf_q) begin
            if (dec_ovf) begin
              dovf_d = 1'b1;
            end else begin
              dec_d = dec_next[SW-1:0];
            end
          end
        end else begin
          dstop_d = 1'b1;
        end
      end
      if (!hstop_q) begin
        if (chr_i.is_hex) begin
          hex_d = {hex_q[HexW-5:0], chr_i.digit};
        end else if (!(chr_i.is_x && wlen_q == 4'd1 && hex_q == '0)) begin
          hstop_d = 1'b1;
        end
      end
    end

    if (clr || restart) begin
      dec_d   = '0;
      hex_d   = '0;
      dstop_d = 1'b0;
      hstop_d = 1'b0;
      dovf_d  = 1'b0;
      word_d  = '0;
      wlen_d  = '0;
    end
    // A newline starts a fresh line, also after a dropped one.
    if (restart) begin
      kind_d      = atrp_pkg::K_NONE;
      held_size_d = '0;
      held_mem_d  = '0;
      held_old_d  = '0;
      discard_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= atrp_pkg::PH_LOC;
      kind_q      <= atrp_pkg::K_NONE;
      dec_q       <= '0;
      hex_q       <= '0;
      dstop_q     <= 1'b0;
      hstop_q     <= 1'b0;
      dovf_q      <= 1'b0;
      word_q      <= '0;
      wlen_q      <= '0;
      held_size_q <= '0;
      held_mem_q  <= '0;
      held_old_q  <= '0;
      discard_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      dec_q       <= dec_d;
      hex_q       <= hex_d;
      dstop_q     <= dstop_d;
      hstop_q     <= hstop_d;
      dovf_q      <= dovf_d;
      word_q      <= word_d;
      wlen_q      <= wlen_d;
      held_size_q <= held_size_d;
      held_mem_q  <= held_mem_d;
      held_old_q  <= held_old_d;
      discard_q   <= discard_d;
    end
  end

endmodule

// File: hw/rtl/alloc_trace_record_parser.sv
// Allocation-trace record parser, top level. Takes one character word per cycle while full is low.
// Throughput: one character per cycle, sustained while results are taken as fast.
// A record reaches the result ports through the character queue, the combinational parse
// logic of the back and the result queue.
// Reset clears both queues and all line state at once; no clearing pass is needed.
// Depends on atrp_pkg, atrp_front, atrp_back and atrp_fifo.
module alloc_trace_record_parser #(
  parameter int unsigned WORD_CHARS   = atrp_pkg::WORD_CHARS_DEF,
  parameter int unsigned POINTER_BITS = atrp_pkg::POINTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind_o,
  output logic [62:0] alloc_size_o,
  output logic [62:0] member_count_o,
  output logic [31:0] old_pointer_o,
  output logic [31:0] new_pointer_o,
  output logic [2:0]  error_code_o
);

  atrp_pkg::chr_t chr;
  logic           chr_empty, chr_pop;
  atrp_pkg::rec_t rec_in, rec_out;
  logic           rec_push, rec_full;

  // Front: accept and classify.
  atrp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ch_i    (ch_i),
    .full_o  (full),
    .pop_i   (chr_pop),
    .chr_o   (chr),
    .empty_o (chr_empty)
  );

  // Back: parse the line and build records.
  atrp_back #(
    .WORD_CHARS   (WORD_CHARS),
    .POINTER_BITS (POINTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chr_i       (chr),
    .chr_valid_i (!chr_empty),
    .chr_pop_o   (chr_pop),
    .rec_full_i  (rec_full),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  // Result queue keeps the parser running while a record waits.
  atrp_fifo #(
    .item_t (atrp_pkg::rec_t),
    .Depth  (atrp_pkg::REC_Q_DEPTH)
  ) u_rec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (pop),
    .data_o  (rec_out),
    .empty_o (empty)
  );

  assign event_kind_o   = rec_out.event_kind;
  assign alloc_size_o   = rec_out.alloc_size;
  assign member_count_o = rec_out.member_count;
  assign old_pointer_o  = rec_out.old_pointer;
  assign new_pointer_o  = rec_out.new_pointer;
  assign error_code_o   = rec_out.error_code;

endmodule

// File: hw/rtl/atrp_checker.sv
// Port-level checks of the trace parser, attached to the top level by bind.
// Depends on atrp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module atrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  event_kind_o,
  input logic [62:0] alloc_size_o,
  input logic [62:0] member_count_o,
  input logic [31:0] old_pointer_o,
  input logic [31:0] new_pointer_o,
  input logic [2:0]  error_code_o
);

  logic         rec_valid, rec_err, rec_ok, code_known, all_zero, unused_zero;
  logic [194:0] rec_word;

  // Qualifiers on the waiting word.
  assign rec_valid  = !empty;
  assign rec_err    = rec_valid && (error_code_o != atrp_pkg::ERR_NONE);
  assign rec_ok     = rec_valid && (error_code_o == atrp_pkg::ERR_NONE);
  assign code_known = (error_code_o <= atrp_pkg::ERR_MISPLACED);
  assign rec_word   = {event_kind_o, alloc_size_o, member_count_o, old_pointer_o,
                       new_pointer_o, error_code_o};

  // An error record shows the zero kind code and empty fields.
  assign all_zero = (event_kind_o == atrp_pkg::EV_MALLOC) && (alloc_size_o == '0) &&
                    (member_count_o == '0) && (old_pointer_o == '0) &&
                    (new_pointer_o == '0);

  // Fields a kind does not use read zero.
  assign unused_zero = (event_kind_o == atrp_pkg::EV_CALLOC || member_count_o == '0) &&
                       (event_kind_o == atrp_pkg::EV_REALLOC || old_pointer_o == '0) &&
                       (event_kind_o != atrp_pkg::EV_FREE || alloc_size_o == '0);

  // An error record carries nothing but its code.
  `ASSERT_IMPLIES(err_rec_zero_a, clk_i, rst_ni, rec_err, all_zero)

  // Error codes stay within the defined set.
  `ASSERT_IMPLIES(err_range_a, clk_i, rst_ni, rec_valid, code_known)

  // A clean record leaves the fields of other kinds at zero.
  `ASSERT_IMPLIES(unused_zero_a, clk_i, rst_ni, rec_ok, unused_zero)

  // A waiting word holds until it is taken.
  `ASSERT_NEXT(hold_a, clk_i, rst_ni, rec_valid && !pop, rec_valid && $stable(rec_word))

endmodule

bind alloc_trace_record_parser atrp_checker u_atrp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .event_kind_o   (event_kind_o),
  .alloc_size_o   (alloc_size_o),
  .member_count_o (member_count_o),
  .old_pointer_o  (old_pointer_o),
  .new_pointer_o  (new_pointer_o),
  .error_code_o   (error_code_o)
);
